FILE: sv/vilp_pkg.sv
// ----------------------------------------------------------------------------
// vilp_pkg
// types and constants shared by the display list parser modules
// ----------------------------------------------------------------------------
package vilp_pkg;

    // parse phases
    typedef enum logic [2:0] {
        PH_ENDED    = 3'd0,
        PH_TYPE     = 3'd1,
        PH_COUNT_HI = 3'd2,
        PH_COUNT_LO = 3'd3,
        PH_INDEX    = 3'd4,
        PH_INDEX_LO = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EV_HEADER = 2'd0,
        EV_INDEX  = 2'd1,
        EV_END    = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        CFG_ATTR_COUNT  = 2'd0,
        CFG_IDS_FIRST   = 2'd1,
        CFG_IDS_SECOND  = 2'd2,
        CFG_WIDE_MASK   = 2'd3
    } t_cfg_index;

    // attribute ids
    localparam logic [7:0] ID_MATRIX   = 8'h00;
    localparam logic [7:0] ID_POSITION = 8'h09;
    localparam logic [7:0] ID_NORMAL   = 8'h0a;
    localparam logic [7:0] ID_COLOR0   = 8'h0b;
    localparam logic [7:0] ID_COLOR1   = 8'h0c;
    localparam logic [7:0] ID_TEX0     = 8'h0d;
    localparam logic [7:0] ID_TEX7     = 8'h14;

    // attribute kinds
    localparam logic [3:0] KIND_MATRIX   = 4'd0;
    localparam logic [3:0] KIND_POSITION = 4'd1;
    localparam logic [3:0] KIND_NORMAL   = 4'd2;
    localparam logic [3:0] KIND_COLOR0   = 4'd3;
    localparam logic [3:0] KIND_TEX0     = 4'd5;
    localparam logic [3:0] KIND_UNKNOWN  = 4'd13;

    localparam int CFG_DATA_W = 64;

    typedef struct packed {
        logic [4:0]   attr_count;
        logic [127:0] attr_ids;     // slot s in bits 8s+7..8s
        logic [15:0]  wide_mask;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        packet_start;
        logic [31:0] packet_size;
    } t_in_item;

    // parser state apart from the attribute slot counter
    typedef struct packed {
        t_phase      phase;
        logic [31:0] bytes_read;
        logic [31:0] size_limit;
        logic [7:0]  current_type;
        logic [15:0] vertex_count;
        logic [15:0] vertex_counter;
        logic [7:0]  high_byte;
    } t_state;

    typedef struct packed {
        t_event      event_kind;
        logic [7:0]  prim_type;
        logic [15:0] vertex_total;
        logic [15:0] vertex_number;
        logic [3:0]  attr_kind;
        logic [15:0] index_value;
        logic        last_in_vertex;
        logic        last_in_prim;
    } t_result;

    function automatic logic [3:0] kind_of(input logic [7:0] id);
        logic [3:0] k;
        priority if (id == ID_MATRIX) begin
            k = KIND_MATRIX;
        end else if (id == ID_POSITION) begin
            k = KIND_POSITION;
        end else if (id == ID_NORMAL) begin
            k = KIND_NORMAL;
        end else if (id == ID_COLOR0 || id == ID_COLOR1) begin
            k = KIND_COLOR0 + 4'(id - ID_COLOR0);
        end else if (id >= ID_TEX0 && id <= ID_TEX7) begin
            k = KIND_TEX0 + 4'(id - ID_TEX0);
        end else begin
            k = KIND_UNKNOWN;
        end
        return k;
    endfunction

endpackage

FILE: sv/vilp_in_if.sv
// ----------------------------------------------------------------------------
// vilp_in_if
// byte channel into the display list parser
// ----------------------------------------------------------------------------
interface vilp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        packet_start;
    logic [31:0] packet_size;

    modport source (output valid, data_byte, packet_start, packet_size, input ready);
    modport sink   (input valid, data_byte, packet_start, packet_size, output ready);
endinterface

FILE: sv/vilp_out_if.sv
// ----------------------------------------------------------------------------
// vilp_out_if
// event channel out of the display list parser
// ----------------------------------------------------------------------------
interface vilp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  prim_type;
    logic [15:0] vertex_total;
    logic [15:0] vertex_number;
    logic [3:0]  attr_kind;
    logic [15:0] index_value;
    logic        last_in_vertex;
    logic        last_in_prim;

    modport source (output valid, event_kind, prim_type, vertex_total, vertex_number,
                    attr_kind, index_value, last_in_vertex, last_in_prim, input ready);
    modport sink   (input valid, event_kind, prim_type, vertex_total, vertex_number,
                    attr_kind, index_value, last_in_vertex, last_in_prim, output ready);
endinterface

FILE: sv/vilp_cfg_regs.sv
// ----------------------------------------------------------------------------
// vilp_cfg_regs
// configuration registers written through the plain write port
// ----------------------------------------------------------------------------
module vilp_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [vilp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output vilp_pkg::t_cfg                     o_cfg
);
    import vilp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ATTR_COUNT: r_cfg.attr_count       <= i_cfg_data[4:0];
                CFG_IDS_FIRST:  r_cfg.attr_ids[63:0]   <= i_cfg_data;
                CFG_IDS_SECOND: r_cfg.attr_ids[127:64] <= i_cfg_data;
                CFG_WIDE_MASK:  r_cfg.wide_mask        <= i_cfg_data[15:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: sv/vilp_step.sv
// ----------------------------------------------------------------------------
// vilp_step
// next parser state and event for one packet byte
// ----------------------------------------------------------------------------
module vilp_step #(
    parameter int MAX_ATTRS = 16,
    parameter int SLOT_W    = 4
) (
    input  vilp_pkg::t_cfg      i_cfg,
    input  vilp_pkg::t_in_item  i_item,
    input  vilp_pkg::t_state    i_state,
    input  logic [SLOT_W-1:0]   i_slot,
    output vilp_pkg::t_state    o_state,
    output logic [SLOT_W-1:0]   o_slot,
    output logic                o_has_result,
    output vilp_pkg::t_result   o_result
);
    import vilp_pkg::*;

    t_state            s;
    t_result           res;
    logic [SLOT_W-1:0] slot;
    logic [3:0]        slot4;
    logic [4:0]        n_used;
    logic              has;
    logic              do_emit;
    logic [15:0]       emit_value;
    logic              lv;
    logic              lp;
    logic [7:0]        id;
    logic [7:0]        b;

    // attr_count above the slot limit is clamped
    assign n_used = (i_cfg.attr_count > 5'(MAX_ATTRS)) ? 5'(MAX_ATTRS) : i_cfg.attr_count;
    assign b      = i_item.data_byte;

    always_comb begin
        s          = i_state;
        slot       = i_slot;
        res        = '0;
        has        = 1'b0;
        do_emit    = 1'b0;
        emit_value = '0;
        lv         = 1'b0;
        lp         = 1'b0;
        id         = '0;
        slot4      = '0;

        if (i_item.packet_start) begin
            s.bytes_read     = '0;
            s.size_limit     = i_item.packet_size;
            s.vertex_counter = '0;
            slot             = '0;
            s.phase          = PH_TYPE;
        end

        if (s.phase != PH_ENDED) begin
            if (s.bytes_read != '1) begin
                s.bytes_read = s.bytes_read + 32'd1;
            end
            slot4 = 4'(slot);
            unique case (s.phase)
                PH_TYPE: begin
                    if (b == 8'd0 || s.bytes_read >= s.size_limit) begin
                        s.phase        = PH_ENDED;
                        has            = 1'b1;
                        res.event_kind = EV_END;
                        res.prim_type  = b;
                    end else begin
                        s.current_type = b;
                        s.phase        = PH_COUNT_HI;
                    end
                end
                PH_COUNT_HI: begin
                    s.high_byte = b;
                    s.phase     = PH_COUNT_LO;
                end
                PH_COUNT_LO: begin
                    s.vertex_count   = {s.high_byte, b};
                    s.vertex_counter = '0;
                    slot             = '0;
                    s.phase = (s.vertex_count == 16'd0 || n_used == 5'd0) ? PH_TYPE : PH_INDEX;
                    has              = 1'b1;
                    res.event_kind   = EV_HEADER;
                    res.prim_type    = s.current_type;
                    res.vertex_total = s.vertex_count;
                end
                PH_INDEX: begin
                    if (i_cfg.wide_mask[slot4]) begin
                        s.high_byte = b;
                        s.phase     = PH_INDEX_LO;
                    end else begin
                        do_emit    = 1'b1;
                        emit_value = {8'h00, b};
                    end
                end
                PH_INDEX_LO: begin
                    do_emit    = 1'b1;
                    emit_value = {s.high_byte, b};
                end
                default: begin
                    s.phase = PH_ENDED;
                end
            endcase

            if (do_emit) begin
                lv = ({1'b0, slot4} + 5'd1) >= n_used;
                lp = lv && (({1'b0, s.vertex_counter} + 17'd1) >= {1'b0, s.vertex_count});
                id = i_cfg.attr_ids[{slot4, 3'b000} +: 8];
                has                = 1'b1;
                res.event_kind     = EV_INDEX;
                res.prim_type      = s.current_type;
                res.vertex_total   = s.vertex_count;
                res.vertex_number  = s.vertex_counter;
                res.attr_kind      = kind_of(id);
                res.index_value    = emit_value;
                res.last_in_vertex = lv;
                res.last_in_prim   = lp;
                if (lv) begin
                    slot             = '0;
                    s.vertex_counter = s.vertex_counter + 16'd1;
                    s.phase          = lp ? PH_TYPE : PH_INDEX;
                end else begin
                    slot    = slot + SLOT_W'(1);
                    s.phase = PH_INDEX;
                end
            end
        end
    end

    assign o_state      = s;
    assign o_slot       = slot;
    assign o_has_result = has;
    assign o_result     = res;

endmodule

FILE: sv/vertex_index_list_parser_top.sv
// ----------------------------------------------------------------------------
// vertex_index_list_parser_top
// indexed vertex display list parser, one packet byte per word
// ----------------------------------------------------------------------------
// usage
//   i_in carries one packet byte per word with packet_start and packet_size;
//   packet_start restarts the parser and its byte is read as a type byte.
//   o_out carries header, index and packet-end events, zero or one per byte.
//   configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while the block is idle.
// timing
//   a byte is taken into an input register and parsed there; its event, if
//   any, goes into the output register, which drives o_out.
//   throughput is one byte per cycle while no event waits on a stalled o_out,
//   set by the phase and counter update that feeds back on itself each byte.
// reset
//   synchronous active-low reset empties both stages, clears the parser state
//   and configuration and leaves the parser ended, waiting for a packet start.
// stall
//   while o_out is stalled the output register holds its event; bytes with no
//   event go on being taken and parsed, until a byte with an event waits in
//   the input register.
// ----------------------------------------------------------------------------
module vertex_index_list_parser_top #(
    parameter int MAX_ATTRS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_index,
    input  logic [vilp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    vilp_in_if.sink                          i_in,
    vilp_out_if.source                       o_out
);
    import vilp_pkg::*;

    localparam int SLOT_W = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;

    t_cfg              cfg;
    t_in_item          r_in;
    logic              r_in_valid;
    t_state            r_state;
    t_state            n_state;
    logic [SLOT_W-1:0] r_attr_slot;
    logic [SLOT_W-1:0] n_attr_slot;
    logic              has_result;
    t_result           result;
    t_result           r_out;
    logic              r_out_valid;
    logic              out_free;
    logic              process;

    vilp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    vilp_step #(
        .MAX_ATTRS (MAX_ATTRS),
        .SLOT_W    (SLOT_W)
    ) u_step (
        .i_cfg        (cfg),
        .i_item       (r_in),
        .i_state      (r_state),
        .i_slot       (r_attr_slot),
        .o_state      (n_state),
        .o_slot       (n_attr_slot),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // a byte with no event never waits for the output register
    assign out_free   = !r_out_valid || o_out.ready;
    assign process    = r_in_valid && (!has_result || out_free);
    assign i_in.ready = !r_in_valid || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.data_byte    <= i_in.data_byte;
            r_in.packet_start <= i_in.packet_start;
            r_in.packet_size  <= i_in.packet_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_ENDED;
            r_state.bytes_read     <= '0;
            r_state.size_limit     <= '0;
            r_state.current_type   <= '0;
            r_state.vertex_count   <= '0;
            r_state.vertex_counter <= '0;
            r_state.high_byte      <= '0;
            r_attr_slot            <= '0;
        end else if (process) begin
            r_state     <= n_state;
            r_attr_slot <= n_attr_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && has_result) begin
            r_out <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.event_kind     = r_out.event_kind;
    assign o_out.prim_type      = r_out.prim_type;
    assign o_out.vertex_total   = r_out.vertex_total;
    assign o_out.vertex_number  = r_out.vertex_number;
    assign o_out.attr_kind      = r_out.attr_kind;
    assign o_out.index_value    = r_out.index_value;
    assign o_out.last_in_vertex = r_out.last_in_vertex;
    assign o_out.last_in_prim   = r_out.last_in_prim;

    // both stages are empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

    // slot counter stays inside the MAX_ATTRS slot range
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_attr_slot <= SLOT_W'(MAX_ATTRS - 1))
        else $error("attribute slot out of range");

    // a packet-end event leaves the parser ended
    a_end_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && has_result && result.event_kind == EV_END
        |=> r_state.phase == PH_ENDED)
        else $error("parser not ended after packet end");

    // the last index of a primitive returns to a type byte
    a_prim_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && has_result && result.event_kind == EV_INDEX && result.last_in_prim
        |=> r_state.phase == PH_TYPE)
        else $error("parser not at type byte after last index");

    // a held byte is never dropped from the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !process |=> r_in_valid && $stable(r_in))
        else $error("held input byte lost");

endmodule

FILE: verif/vertex_index_list_parser_top_tb.sv
// ----------------------------------------------------------------------------
// vertex_index_list_parser_top_tb
// self-checking bench for the indexed vertex display list parser
// ----------------------------------------------------------------------------
// Packet bytes go in one word at a time. An in-bench parser follows every
// accepted byte and queues the event that the byte should cause. Each event
// that comes out is checked field by field against the oldest queued one.
// A short directed table comes first: ignored bytes, narrow and wide
// indices, the widest vertex count, a restart mid-primitive, an empty
// primitive, the end of a packet by byte limit and by a zero type byte.
// Then come random packets under a run of attribute setups, from all-zero to
// all-ones. Most are well-formed, some are cut short, some are noise. Both
// sides idle at random, and once the event side stalls for a long stretch.
// ----------------------------------------------------------------------------
module vertex_index_list_parser_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vilp_pkg::*;

    localparam int SLOT_LIMIT      = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES          = 12;
    localparam int PHASE_BYTES     = 85;

    typedef enum logic [1:0] {
        CHK_MODEL  = 2'd0,
        CHK_NONE   = 2'd1,
        CHK_HEADER = 2'd2,
        CHK_END    = 2'd3
    } t_check_kind;

    typedef struct packed {
        t_check_kind chk;
        logic [7:0]  tp;
        logic [15:0] total;
    } t_fixed;

    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic [31:0] size;
        t_check_kind chk;
        logic [7:0]  tp;
        logic [15:0] total;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                   i_cfg_we;
    logic [1:0]             i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    vilp_in_if  in_if ();
    vilp_out_if out_if ();

    vertex_index_list_parser_top #(
        .MAX_ATTRS (SLOT_LIMIT)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #2 i_clk = ~i_clk;

    // configuration as last written
    logic [4:0]   cfg_attr_count = '0;
    logic [127:0] cfg_attr_ids   = '0;
    logic [15:0]  cfg_wide_mask  = '0;

    // parser state as the bench sees it
    t_phase      dl_phase  = PH_ENDED;
    logic [31:0] dl_bytes  = '0;
    logic [31:0] dl_limit  = '0;
    logic [7:0]  dl_type   = '0;
    logic [15:0] dl_vtotal = '0;
    logic [15:0] dl_vnum   = '0;
    logic [3:0]  dl_slot   = '0;
    logic [7:0]  dl_hi     = '0;

    t_result events_due[$];
    t_fixed  fixed_checks[$];
    int      mismatches    = 0;
    bit      no_idle       = 1'b0;
    bit      hold_off_req  = 1'b0;

    t_row directed_rows [22] = '{
        '{8'h55, 1'b0, 32'h0000_0000, CHK_NONE,   8'h00, 16'h0000},  // ended, ignored
        '{8'h90, 1'b1, 32'hFFFF_FFFF, CHK_NONE,   8'h00, 16'h0000},
        '{8'h00, 1'b0, 32'h0000_0000, CHK_NONE,   8'h00, 16'h0000},
        '{8'h02, 1'b0, 32'h0000_0000, CHK_HEADER, 8'h90, 16'h0002},
        '{8'hFF, 1'b0, 32'h0000_0000, CHK_MODEL,  8'h00, 16'h0000},
        '{8'hAB, 1'b0, 32'h0000_0000, CHK_NONE,   8'h00, 16'h0000},  // wide, high byte
        '{8'hCD, 1'b0, 32'h0000_0000, CHK_MODEL,  8'h00, 16'h0000},
        '{8'h00, 1'b0, 32'h0000_0000, CHK_MODEL,  8'h00, 16'h0000},
        '{8'h01, 1'b0, 32'hFFFF_FFFF, CHK_MODEL,  8'h00, 16'h0000},
        '{8'hFF, 1'b0, 32'h0000_0000, CHK_NONE,   8'h00, 16'h0000},
        '{8'hFF, 1'b0, 32'h0000_0000, CHK_MODEL,  8'h00, 16'h0000},
        '{8'h7F, 1'b0, 32'h0000_0000, CHK_MODEL,  8'h00, 16'h0000},
        '{8'h98, 1'b0, 32'h0000_0000, CHK_NONE,   8'h00, 16'h0000},
        '{8'hFF, 1'b0, 32'h0000_0000, CHK_NONE,   8'h00, 16'h0000},
        '{8'hFF, 1'b0, 32'h0000_0000, CHK_HEADER, 8'h98, 16'hFFFF},
        '{8'hA0, 1'b1, 32'h0000_0003, CHK_NONE,   8'h00, 16'h0000},  // restart mid-primitive
        '{8'h00, 1'b0, 32'h0000_0000, CHK_NONE,   8'h00, 16'h0000},
        '{8'h00, 1'b0, 32'h0000_0000, CHK_HEADER, 8'hA0, 16'h0000},  // no vertices
        '{8'hB8, 1'b0, 32'h0000_0000, CHK_END,    8'h00, 16'h0000},  // past the byte limit
        '{8'h80, 1'b1, 32'h0000_0000, CHK_END,    8'h00, 16'h0000},
        '{8'h00, 1'b1, 32'h0000_0064, CHK_END,    8'h00, 16'h0000},  // zero type byte
        '{8'h90, 1'b1, 32'h0000_0001, CHK_END,    8'h00, 16'h0000}
    };

    function automatic int slots_in_use();
        return (int'(cfg_attr_count) > SLOT_LIMIT) ? SLOT_LIMIT : int'(cfg_attr_count);
    endfunction

    function automatic logic [3:0] kind_for_id(logic [7:0] id);
        if (id == ID_MATRIX) return KIND_MATRIX;
        // position, normal, colours and texcoords sit on consecutive ids
        if (id >= ID_POSITION && id <= ID_TEX7) return KIND_POSITION + 4'(id - ID_POSITION);
        return KIND_UNKNOWN;
    endfunction

    function automatic t_result index_event(logic [15:0] value);
        t_result ev;
        bit      lv;
        bit      lp;
        lv = (int'(dl_slot) + 1 >= slots_in_use());
        lp = lv && (int'(dl_vnum) + 1 >= int'(dl_vtotal));
        ev = '0;
        ev.event_kind     = EV_INDEX;
        ev.prim_type      = dl_type;
        ev.vertex_total   = dl_vtotal;
        ev.vertex_number  = dl_vnum;
        ev.attr_kind      = kind_for_id(cfg_attr_ids[8*dl_slot +: 8]);
        ev.index_value    = value;
        ev.last_in_vertex = lv;
        ev.last_in_prim   = lp;
        if (lv) begin
            dl_slot  = '0;
            dl_vnum  = dl_vnum + 16'd1;
            dl_phase = lp ? PH_TYPE : PH_INDEX;
        end else begin
            dl_slot  = dl_slot + 4'd1;
            dl_phase = PH_INDEX;
        end
        return ev;
    endfunction

    // advance the parser by one byte; 1 when the byte yields an event
    function automatic bit parse_byte(input t_in_item it, output t_result ev);
        logic [7:0] b;
        b  = it.data_byte;
        ev = '0;
        if (it.packet_start) begin
            dl_bytes = '0;
            dl_limit = it.packet_size;
            dl_vnum  = '0;
            dl_slot  = '0;
            dl_phase = PH_TYPE;
        end
        if (dl_phase == PH_ENDED) return 1'b0;
        if (dl_bytes != 32'hFFFF_FFFF) dl_bytes = dl_bytes + 32'd1;
        case (dl_phase)
            PH_TYPE: begin
                if (b == 8'h00 || dl_bytes >= dl_limit) begin
                    dl_phase      = PH_ENDED;
                    ev.event_kind = EV_END;
                    ev.prim_type  = b;
                    return 1'b1;
                end
                dl_type  = b;
                dl_phase = PH_COUNT_HI;
                return 1'b0;
            end
            PH_COUNT_HI: begin
                dl_hi    = b;
                dl_phase = PH_COUNT_LO;
                return 1'b0;
            end
            PH_COUNT_LO: begin
                dl_vtotal = {dl_hi, b};
                dl_vnum   = '0;
                dl_slot   = '0;
                dl_phase  = (dl_vtotal == 16'd0 || slots_in_use() == 0) ? PH_TYPE : PH_INDEX;
                ev.event_kind   = EV_HEADER;
                ev.prim_type    = dl_type;
                ev.vertex_total = dl_vtotal;
                return 1'b1;
            end
            PH_INDEX: begin
                if (cfg_wide_mask[dl_slot]) begin
                    dl_hi    = b;
                    dl_phase = PH_INDEX_LO;
                    return 1'b0;
                end
                ev = index_event({8'h00, b});
                return 1'b1;
            end
            PH_INDEX_LO: begin
                ev = index_event({dl_hi, b});
                return 1'b1;
            end
            default: begin
                dl_phase = PH_ENDED;
                return 1'b0;
            end
        endcase
    endfunction

    // mostly back to back, now and then a long pause
    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item plain_byte(logic [7:0] b);
        t_in_item it;
        it.data_byte    = b;
        it.packet_start = 1'b0;
        it.packet_size  = $urandom;
        return it;
    endfunction

    task automatic offer_byte(t_in_item it, t_check_kind chk, logic [7:0] tp,
                              logic [15:0] total);
        int     gap;
        t_fixed fx;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        fx.chk   = chk;
        fx.tp    = tp;
        fx.total = total;
        fixed_checks = {fixed_checks, fx};
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= it.data_byte;
        in_if.packet_start <= it.packet_start;
        in_if.packet_size  <= it.packet_size;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic load_config(logic [4:0] cnt, logic [127:0] ids, logic [15:0] mask);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ATTR_COUNT;
        i_cfg_data  <= 64'(cnt);
        @(posedge i_clk);
        i_cfg_index <= CFG_IDS_FIRST;
        i_cfg_data  <= ids[63:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_IDS_SECOND;
        i_cfg_data  <= ids[127:64];
        @(posedge i_clk);
        i_cfg_index <= CFG_WIDE_MASK;
        i_cfg_data  <= 64'(mask);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_attr_count = cnt;
        cfg_attr_ids   = ids;
        cfg_wide_mask  = mask;
    endtask

    // stop offering, let every queued event out, then let eventless bytes drain
    task automatic wait_parser_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (events_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_packet(output int counted);
        t_in_item    pkt[$];
        t_in_item    it;
        int          mode;
        int          nprim;
        int          ending;
        int          extra;
        logic [15:0] vc;
        logic [31:0] size;
        mode    = $urandom_range(0, 99);
        counted = 0;
        if (mode < 75) begin
            nprim = $urandom_range(0, 3);
            for (int p = 0; p < nprim; p++) begin
                pkt = {pkt, plain_byte(8'($urandom_range(1, 255)))};
                vc = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(4, 8))
                                                  : 16'($urandom_range(0, 3));
                pkt = {pkt, plain_byte(vc[15:8])};
                pkt = {pkt, plain_byte(vc[7:0])};
                for (int v = 0; v < int'(vc); v++) begin
                    for (int s = 0; s < slots_in_use(); s++) begin
                        if (cfg_wide_mask[s]) pkt = {pkt, plain_byte(8'($urandom))};
                        pkt = {pkt, plain_byte(8'($urandom))};
                    end
                end
            end
            ending = $urandom_range(0, 2);
            case (ending)
                0: begin
                    size = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                : 32'(pkt.size() + 1 + $urandom_range(0, 50));
                    pkt = {pkt, plain_byte(8'h00)};
                end
                1: begin
                    size = 32'(pkt.size() + 1);
                    pkt = {pkt, plain_byte(8'($urandom_range(1, 255)))};
                end
                default: begin
                    // limit may fall at an earlier type byte
                    size = 32'($urandom_range(0, pkt.size()));
                    pkt = {pkt, plain_byte(8'($urandom))};
                end
            endcase
            pkt[0].packet_start = 1'b1;
            pkt[0].packet_size  = size;
            counted = pkt.size();
            if ($urandom_range(0, 4) == 0) begin
                extra = $urandom_range(1, 3);
                repeat (extra) pkt = {pkt, plain_byte(8'($urandom))};
            end
        end else if (mode < 90) begin
            // cut short by the next packet start
            pkt = {pkt, plain_byte(8'($urandom_range(1, 255)))};
            pkt = {pkt, plain_byte(8'($urandom))};
            pkt = {pkt, plain_byte(8'($urandom))};
            extra = $urandom_range(0, 10);
            repeat (extra) pkt = {pkt, plain_byte(8'($urandom))};
            pkt[0].packet_start = 1'b1;
            counted = pkt.size();
        end else begin
            extra = $urandom_range(1, 6);
            repeat (extra) begin
                it = plain_byte(8'($urandom));
                it.packet_start = ($urandom_range(0, 4) == 0);
                pkt = {pkt, it};
            end
        end
        foreach (pkt[i]) offer_byte(pkt[i], CHK_MODEL, 8'h00, 16'h0000);
    endtask

    task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : accept_word
        t_in_item it;
        t_fixed   fx;
        t_result  ev;
        bit       hit;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            it.data_byte    = in_if.data_byte;
            it.packet_start = in_if.packet_start;
            it.packet_size  = in_if.packet_size;
            fx  = fixed_checks.pop_front();
            hit = parse_byte(it, ev);
            case (fx.chk)
                CHK_MODEL: begin
                    if (hit) events_due = {events_due, ev};
                end
                CHK_HEADER: begin
                    ev = '0;
                    ev.event_kind   = EV_HEADER;
                    ev.prim_type    = fx.tp;
                    ev.vertex_total = fx.total;
                    events_due = {events_due, ev};
                end
                CHK_END: begin
                    ev = '0;
                    ev.event_kind = EV_END;
                    ev.prim_type  = it.data_byte;
                    events_due = {events_due, ev};
                end
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_event
        t_result exp_ev;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (events_due.size() == 0) begin
                $error("event word with no expectation waiting, kind %h", out_if.event_kind);
                mismatches++;
            end else begin
                exp_ev = events_due.pop_front();
                compare_field("event_kind", 16'(exp_ev.event_kind), 16'(out_if.event_kind));
                compare_field("prim_type", 16'(exp_ev.prim_type), 16'(out_if.prim_type));
                compare_field("vertex_total", exp_ev.vertex_total, out_if.vertex_total);
                compare_field("vertex_number", exp_ev.vertex_number, out_if.vertex_number);
                compare_field("attr_kind", 16'(exp_ev.attr_kind), 16'(out_if.attr_kind));
                compare_field("index_value", exp_ev.index_value, out_if.index_value);
                compare_field("last_in_vertex", 16'(exp_ev.last_in_vertex),
                              16'(out_if.last_in_vertex));
                compare_field("last_in_prim", 16'(exp_ev.last_in_prim),
                              16'(out_if.last_in_prim));
            end
        end
    end

    // event side back-pressure, with one long hold-off on request
    initial begin : event_sink
        int rx_wait;
        rx_wait = 0;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
                out_if.ready <= 1'b1;
            end else if (rx_wait > 0) begin
                out_if.ready <= 1'b0;
                rx_wait--;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) rx_wait = pick_gap();
            end
        end
    end

    initial begin : run_limit
        #4_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        t_in_item     it;
        logic [4:0]   cnt;
        logic [127:0] ids;
        logic [15:0]  mask;
        int           phase_bytes;
        int           counted;
        int           pick;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = CFG_ATTR_COUNT;
        i_cfg_data         = '0;
        in_if.valid        = 1'b0;
        in_if.data_byte    = '0;
        in_if.packet_start = 1'b0;
        in_if.packet_size  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // slot 0 position narrow, slot 1 texcoord7 wide, slot 2 unknown narrow
        load_config(5'd3, {104'h0, 8'hFF, ID_TEX7, ID_POSITION}, 16'h0002);
        foreach (directed_rows[i]) begin
            it.data_byte    = directed_rows[i].data;
            it.packet_start = directed_rows[i].start;
            it.packet_size  = directed_rows[i].size;
            offer_byte(it, directed_rows[i].chk, directed_rows[i].tp, directed_rows[i].total);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_parser_idle();
            case (ph)
                0: begin
                    cnt  = '0;
                    ids  = '0;
                    mask = '0;
                end
                1: begin
                    cnt  = '1;
                    ids  = '1;
                    mask = '1;
                end
                2: begin
                    cnt = 5'd16;
                    for (int s = 0; s < SLOT_LIMIT; s++) begin
                        if (s < 12) ids[8*s +: 8] = ID_POSITION + 8'(s);
                        else if (s == 12) ids[8*s +: 8] = ID_MATRIX;
                        else ids[8*s +: 8] = 8'($urandom);
                    end
                    mask = 16'($urandom);
                end
                default: begin
                    cnt = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(1, 5));
                    for (int s = 0; s < SLOT_LIMIT; s++) begin
                        pick = $urandom_range(0, 3);
                        if (pick == 0) ids[8*s +: 8] = ID_MATRIX;
                        else if (pick < 3) ids[8*s +: 8] = 8'($urandom_range(ID_TEX7, ID_POSITION));
                        else ids[8*s +: 8] = 8'($urandom);
                    end
                    mask = 16'($urandom);
                end
            endcase
            load_config(cnt, ids, mask);
            no_idle = (ph % 4 == 3);
            if (ph == 2) hold_off_req = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                send_packet(counted);
                phase_bytes += counted;
            end
        end

        wait_parser_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && events_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/vilp_pkg.sv
sv/vilp_in_if.sv
sv/vilp_out_if.sv
sv/vilp_cfg_regs.sv
sv/vilp_step.sv
sv/vertex_index_list_parser_top.sv
verif/vertex_index_list_parser_top_tb.sv
